// File: sv/mbrq_pkg.sv
// shared types, function codes and crc helper for the modbus request framer
`default_nettype none

package mbrq_pkg;

    // function request codes on the input word
    localparam logic [1:0] FUNC_READ_HOLDING   = 2'd0;
    localparam logic [1:0] FUNC_WRITE_SINGLE   = 2'd1;
    localparam logic [1:0] FUNC_WRITE_MULTIPLE = 2'd2;

    // function code bytes placed in the frame
    localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
    localparam logic [7:0] FC_WRITE_SINGLE   = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    // byte index within one item, at most nine bytes
    localparam int IDX_W = 4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  device_id;
        logic [1:0]  function_req;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic [15:0] word_value;
    } in_word_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       error;
    } out_word_t;

    // what one item turns into
    typedef enum logic [2:0] {
        MODE_ERROR,
        MODE_READ,
        MODE_WRITE_SINGLE,
        MODE_WM_HEADER,
        MODE_WM_EMPTY,
        MODE_DATA,
        MODE_DATA_LAST
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [IDX_W-1:0] idx;
    } sel_ctrl_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       error;
        logic       is_data;   // byte goes through the crc
        logic       item_end;  // final byte of this item
    } sel_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/modbus_request_frame_encoder.sv
// top level of the modbus rtu master request framer
// usage:
//   s_ channel takes request words: a header (device id, function, start
//   address, quantity or value) or a data word of a write-multiple request
//   m_ channel gives the frame one byte per word; last_byte marks the high
//   crc byte that closes a frame, and a rejected word yields a single word
//   with error and last_byte set and frame_byte zero
//   a write-multiple header opens a frame that the next data words continue;
//   the crc of the open frame is carried between words
// timing:
//   a word taken into the input register sends its bytes to m_ through the
//   output register; an input word yields 1 byte if rejected, 2 for a data
//   word, 4 for the closing data word, 7 for a write-multiple header, 8 for
//   read or write-single, 9 for an empty write multiple; while m_ready stays
//   high one byte leaves per cycle, set by the single output register,
//   and the next word is taken in the cycle that the current one emits
//   its final byte, so one-byte words flow at one per cycle
// reset: aresetn low clears both channels, pending word count and crc
// stall: while m_ready is low the output word holds and the input register
//   fills and then drops s_ready
`default_nettype none

module modbus_request_frame_encoder
    import mbrq_pkg::*;
#(
    parameter int MAX_WORDS = 123
) (
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  wire       m_ready,
    output out_word_t m_data
);

    // input register: holds the word being turned into bytes
    logic             in_valid_reg, in_valid_next;
    in_word_t         in_word_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    mode_t            mode_reg, mode_next;

    // frame state carried across words
    logic [15:0]      crc_reg, crc_next;
    logic [6:0]       pending_reg, pending_next;

    // output register
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_word_reg, m_word_next;

    logic             out_free;
    logic             emit;
    logic             item_done;
    mode_t            mode_now;
    mode_t            mode_cur;
    sel_ctrl_t        ctrl;
    sel_t             sel;

    // decide what the word is on its first byte, against the pending count
    always_comb begin
        if (in_word_reg.kind == KIND_DATA) begin
            if (pending_reg == 7'd0) begin
                mode_now = MODE_ERROR;
            end else if (pending_reg == 7'd1) begin
                mode_now = MODE_DATA_LAST;
            end else begin
                mode_now = MODE_DATA;
            end
        end else if (pending_reg != 7'd0) begin
            mode_now = MODE_ERROR;       // header while a frame is open
        end else if (in_word_reg.function_req == FUNC_READ_HOLDING) begin
            mode_now = MODE_READ;
        end else if (in_word_reg.function_req == FUNC_WRITE_SINGLE) begin
            mode_now = MODE_WRITE_SINGLE;
        end else if (in_word_reg.quantity > 16'(MAX_WORDS)) begin
            mode_now = MODE_ERROR;       // too many registers for one frame
        end else if (in_word_reg.quantity == 16'd0) begin
            mode_now = MODE_WM_EMPTY;
        end else begin
            mode_now = MODE_WM_HEADER;
        end
    end

    assign mode_cur  = (idx_reg == '0) ? mode_now : mode_reg;
    assign ctrl.mode = mode_cur;
    assign ctrl.idx  = idx_reg;

    mbrq_byte_sel u_byte_sel (
        .item (in_word_reg),
        .ctrl (ctrl),
        .crc  (crc_reg),
        .sel  (sel)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = in_valid_reg && out_free;
    assign item_done = emit && sel.item_end;
    assign s_ready   = !in_valid_reg || item_done;

    always_comb begin
        in_valid_next = in_valid_reg;
        idx_next      = idx_reg;
        mode_next     = mode_reg;
        crc_next      = crc_reg;
        pending_next  = pending_reg;
        m_valid_next  = m_valid_reg;
        m_word_next   = m_word_reg;

        if (out_free) begin
            m_valid_next = 1'b0;
        end

        if (emit) begin
            m_valid_next           = 1'b1;
            m_word_next.frame_byte = sel.frame_byte;
            m_word_next.last_byte  = sel.last_byte;
            m_word_next.error      = sel.error;
            mode_next              = mode_cur;
            idx_next               = idx_reg + 4'd1;

            if (sel.is_data) begin
                crc_next = crc_byte(crc_reg, sel.frame_byte);
            end else if (sel.last_byte && !sel.error) begin
                crc_next = CRC_INIT;     // frame closed
            end

            // pending count moves once per word, on its first byte
            if (idx_reg == '0) begin
                if (mode_cur == MODE_DATA || mode_cur == MODE_DATA_LAST) begin
                    pending_next = pending_reg - 7'd1;
                end else if (mode_cur == MODE_WM_HEADER) begin
                    pending_next = in_word_reg.quantity[6:0];
                end
            end
        end

        if (item_done) begin
            in_valid_next = 1'b0;
            idx_next      = '0;
        end

        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            idx_reg      <= '0;
            mode_reg     <= MODE_ERROR;
            crc_reg      <= CRC_INIT;
            pending_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            idx_reg      <= idx_next;
            mode_reg     <= mode_next;
            crc_reg      <= crc_next;
            pending_reg  <= pending_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_word_reg;

    // an error word is always a lone closing word with a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_word_reg.error |->
            m_word_reg.last_byte && m_word_reg.frame_byte == 8'h00)
        else $error("error word without last_byte or with nonzero byte");

    // an open frame never expects more words than one frame may carry
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 7'(MAX_WORDS))
        else $error("pending word count above limit");

    // with no frame open and no word half done, the crc sits at its seed
    assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg == 7'd0 && idx_reg == '0 |-> crc_reg == CRC_INIT)
        else $error("crc not reseeded between frames");

    // a word is never dropped: the input register only empties on its last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !item_done |=> in_valid_reg)
        else $error("input word lost before its final byte");

endmodule

`default_nettype wire

// File: sv/mbrq_byte_sel.sv
// picks the frame byte for one item at a given byte index
`default_nettype none

module mbrq_byte_sel
    import mbrq_pkg::*;
(
    input  in_word_t    item,
    input  sel_ctrl_t   ctrl,
    input  logic [15:0] crc,
    output sel_t        sel
);

    logic [7:0] fc_byte;

    always_comb begin
        case (item.function_req)
            FUNC_READ_HOLDING: fc_byte = FC_READ_HOLDING;
            FUNC_WRITE_SINGLE: fc_byte = FC_WRITE_SINGLE;
            default:           fc_byte = FC_WRITE_MULTIPLE;
        endcase
    end

    always_comb begin
        sel = '0;
        unique case (ctrl.mode)
            MODE_ERROR: begin
                sel.last_byte = 1'b1;
                sel.error     = 1'b1;
                sel.item_end  = 1'b1;
            end
            MODE_DATA, MODE_DATA_LAST: begin
                case (ctrl.idx)
                    4'd0: begin
                        sel.frame_byte = item.word_value[15:8];
                        sel.is_data    = 1'b1;
                    end
                    4'd1: begin
                        sel.frame_byte = item.word_value[7:0];
                        sel.is_data    = 1'b1;
                        sel.item_end   = (ctrl.mode == MODE_DATA);
                    end
                    4'd2: sel.frame_byte = crc[7:0];
                    default: begin
                        sel.frame_byte = crc[15:8];
                        sel.last_byte  = 1'b1;
                        sel.item_end   = 1'b1;
                    end
                endcase
            end
            default: begin
                // header frames: id, code, address, quantity or value, then byte count or crc
                sel.is_data = 1'b1;
                case (ctrl.idx)
                    4'd0: sel.frame_byte = item.device_id;
                    4'd1: sel.frame_byte = fc_byte;
                    4'd2: sel.frame_byte = item.start_address[15:8];
                    4'd3: sel.frame_byte = item.start_address[7:0];
                    4'd4: sel.frame_byte = (ctrl.mode == MODE_WRITE_SINGLE) ?
                                           item.word_value[15:8] : item.quantity[15:8];
                    4'd5: sel.frame_byte = (ctrl.mode == MODE_WRITE_SINGLE) ?
                                           item.word_value[7:0] : item.quantity[7:0];
                    4'd6: begin
                        if (ctrl.mode == MODE_READ || ctrl.mode == MODE_WRITE_SINGLE) begin
                            sel.frame_byte = crc[7:0];
                            sel.is_data    = 1'b0;
                        end else begin
                            // byte count, two per register
                            sel.frame_byte = {item.quantity[6:0], 1'b0};
                            sel.item_end   = (ctrl.mode == MODE_WM_HEADER);
                        end
                    end
                    4'd7: begin
                        sel.is_data = 1'b0;
                        if (ctrl.mode == MODE_WM_EMPTY) begin
                            sel.frame_byte = crc[7:0];
                        end else begin
                            sel.frame_byte = crc[15:8];
                            sel.last_byte  = 1'b1;
                            sel.item_end   = 1'b1;
                        end
                    end
                    default: begin
                        sel.is_data    = 1'b0;
                        sel.frame_byte = crc[15:8];
                        sel.last_byte  = 1'b1;
                        sel.item_end   = 1'b1;
                    end
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

// File: tb/tb_modbus_request_frame_encoder.sv
// testbench for the modbus rtu request frame encoder: predicted byte stream, random traffic
`timescale 1ns / 100ps

module tb_modbus_request_frame_encoder;
    import mbrq_pkg::*;

    localparam int MAX_WORDS       = 123;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_WORDS    = 100;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // bytes still owed by the block, oldest first
    out_word_t expected_bytes[$];
    int        fail_count = 0;

    // predictor state: crc of the open write-multiple frame and data words it still needs
    logic [15:0] crc_carry  = CRC_INIT;
    logic [6:0]  words_left = '0;

    // sender burst bookkeeping
    int burst_left = 0;

    // receiver long hold-off: the test flips the toggle, the receiver counts the cycles
    bit hold_toggle = 1'b0;

    modbus_request_frame_encoder #(
        .MAX_WORDS(MAX_WORDS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // frame prediction
    // ------------------------------------------------------------------

    // bit-serial modbus crc, data taken lsb first
    function automatic logic [15:0] crc16_modbus(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ b[i];
            r  = {1'b0, r[15:1]};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic push_frame_byte(inout logic [15:0] crc, input logic [7:0] b);
        out_word_t o;
        o.frame_byte = b;
        o.last_byte  = 1'b0;
        o.error      = 1'b0;
        expected_bytes.push_back(o);
        crc = crc16_modbus(crc, b);
    endtask

    // crc trailer goes out low byte first, the high byte closes the frame
    task automatic push_crc_bytes(input logic [15:0] crc);
        out_word_t o;
        o.frame_byte = crc[7:0];
        o.last_byte  = 1'b0;
        o.error      = 1'b0;
        expected_bytes.push_back(o);
        o.frame_byte = crc[15:8];
        o.last_byte  = 1'b1;
        expected_bytes.push_back(o);
    endtask

    task automatic push_reject();
        out_word_t o;
        o.frame_byte = 8'h00;
        o.last_byte  = 1'b1;
        o.error      = 1'b1;
        expected_bytes.push_back(o);
    endtask

    // works out the bytes that one accepted word must produce
    task automatic predict_frame_bytes(input in_word_t w);
        logic [15:0] crc;
        logic [7:0]  code;
        if (w.kind == KIND_DATA) begin
            // stray data word with no frame open
            if (words_left == 0) begin
                push_reject();
                return;
            end
            crc = crc_carry;
            push_frame_byte(crc, w.word_value[15:8]);
            push_frame_byte(crc, w.word_value[7:0]);
            words_left = words_left - 7'd1;
            if (words_left == 0) begin
                push_crc_bytes(crc);
                crc_carry = CRC_INIT;
            end else begin
                crc_carry = crc;
            end
            return;
        end
        // header while a frame is still waiting for data: dropped, frame goes on
        if (words_left != 0) begin
            push_reject();
            return;
        end
        // function code three counts as write multiple, so the size check covers it
        if (w.function_req != FUNC_READ_HOLDING && w.function_req != FUNC_WRITE_SINGLE
                && w.quantity > MAX_WORDS) begin
            push_reject();
            return;
        end
        case (w.function_req)
            FUNC_READ_HOLDING: code = FC_READ_HOLDING;
            FUNC_WRITE_SINGLE: code = FC_WRITE_SINGLE;
            default:           code = FC_WRITE_MULTIPLE;
        endcase
        crc = CRC_INIT;
        push_frame_byte(crc, w.device_id);
        push_frame_byte(crc, code);
        push_frame_byte(crc, w.start_address[15:8]);
        push_frame_byte(crc, w.start_address[7:0]);
        if (w.function_req == FUNC_WRITE_SINGLE) begin
            push_frame_byte(crc, w.word_value[15:8]);
            push_frame_byte(crc, w.word_value[7:0]);
            push_crc_bytes(crc);
            return;
        end
        // read quantity goes out as given, no range check
        push_frame_byte(crc, w.quantity[15:8]);
        push_frame_byte(crc, w.quantity[7:0]);
        if (w.function_req == FUNC_READ_HOLDING) begin
            push_crc_bytes(crc);
            return;
        end
        push_frame_byte(crc, {w.quantity[6:0], 1'b0});
        // empty write multiple closes at once
        if (w.quantity == 0) begin
            crc_carry = CRC_INIT;
            push_crc_bytes(crc);
            return;
        end
        words_left = w.quantity[6:0];
        crc_carry  = crc;
    endtask

    // ------------------------------------------------------------------
    // sender: bursts of random length, random gaps between them
    // every call starts and ends at a falling edge
    // ------------------------------------------------------------------
    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_frame_bytes(w);
        burst_left--;
        @(negedge aclk);
    endtask

    // sender goes quiet until every owed byte has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic in_word_t make_header(input logic [7:0] dev, input logic [1:0] func,
                                             input logic [15:0] addr, input logic [15:0] qty,
                                             input logic [15:0] value);
        in_word_t w;
        w.kind          = KIND_HEADER;
        w.device_id     = dev;
        w.function_req  = func;
        w.start_address = addr;
        w.quantity      = qty;
        w.word_value    = value;
        return w;
    endfunction

    // data word; the header fields carry noise that the block must ignore
    function automatic in_word_t make_data(input logic [15:0] value);
        in_word_t w;
        w.kind          = KIND_DATA;
        w.device_id     = 8'($urandom);
        w.function_req  = 2'($urandom);
        w.start_address = 16'($urandom);
        w.quantity      = 16'($urandom);
        w.word_value    = value;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random ready patterns, plus long hold-offs
    // ------------------------------------------------------------------
    int rx_cycle  = 0;
    int rx_mode   = 0;
    int hold_left = 0;
    bit hold_seen = 1'b0;

    always @(negedge aclk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (rx_cycle % 64 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (rx_cycle % 4 == 0);
                default: m_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output check against the oldest owed byte
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("output word with nothing expected: frame_byte %h last_byte %b error %b",
                       m_data.frame_byte, m_data.last_byte, m_data.error);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_data.frame_byte !== want.frame_byte) begin
                    $error("frame_byte: expected %h, got %h", want.frame_byte, m_data.frame_byte);
                    fail_count++;
                end
                if (m_data.last_byte !== want.last_byte) begin
                    $error("last_byte: expected %b, got %b", want.last_byte, m_data.last_byte);
                    fail_count++;
                end
                if (m_data.error !== want.error) begin
                    $error("error: expected %b, got %b", want.error, m_data.error);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // read holding with extreme ids, addresses and quantities
    task automatic test_read_holding();
        send_word(make_header(8'h00, FUNC_READ_HOLDING, 16'h0000, 16'h0000, 16'hFFFF));
        send_word(make_header(8'hFF, FUNC_READ_HOLDING, 16'hFFFF, 16'hFFFF, 16'h0000));
        send_word(make_header(8'h11, FUNC_READ_HOLDING, 16'h006B, 16'h0003, 16'($urandom)));
        wait_drained();
    endtask

    task automatic test_write_single();
        send_word(make_header(8'hFF, FUNC_WRITE_SINGLE, 16'h0000, 16'hFFFF, 16'h0000));
        send_word(make_header(8'h00, FUNC_WRITE_SINGLE, 16'hFFFF, 16'h0000, 16'hFFFF));
        wait_drained();
    endtask

    // empty frame, one and two words, and function code three acting as write multiple
    task automatic test_write_multiple();
        send_word(make_header(8'h01, FUNC_WRITE_MULTIPLE, 16'h1234, 16'h0000, 16'($urandom)));
        send_word(make_header(8'h02, FUNC_WRITE_MULTIPLE, 16'h0001, 16'h0001, 16'($urandom)));
        send_word(make_data(16'hA5C3));
        send_word(make_header(8'hFE, FUNC_WRITE_MULTIPLE, 16'hFFFF, 16'h0002, 16'($urandom)));
        send_word(make_data(16'h0000));
        send_word(make_data(16'hFFFF));
        send_word(make_header(8'h7F, 2'd3, 16'h8000, 16'h0001, 16'($urandom)));
        send_word(make_data(16'h5A5A));
        wait_drained();
    endtask

    // oversize quantity, stray data word, header in the middle of an open frame
    task automatic test_protocol_errors();
        send_word(make_header(8'h10, FUNC_WRITE_MULTIPLE, 16'h0000, 16'(MAX_WORDS + 1), 16'h0));
        send_word(make_header(8'h10, 2'd3, 16'h0000, 16'hFFFF, 16'h0));
        send_word(make_data(16'h1357));
        send_word(make_header(8'h20, FUNC_WRITE_MULTIPLE, 16'h0040, 16'h0002, 16'h0));
        send_word(make_data(16'h0102));
        send_word(make_header(8'h21, FUNC_READ_HOLDING, 16'h0001, 16'h0001, 16'h0));
        send_word(make_data(16'h0304));
        send_word(make_data(16'hFFFF));
        wait_drained();
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_back_pressure();
        hold_toggle = ~hold_toggle;
        for (int i = 0; i < 24; i++) begin
            send_word(make_header(8'($urandom), 2'($urandom_range(0, 1)), 16'($urandom),
                                  16'($urandom), 16'($urandom)));
        end
        wait_drained();
    endtask

    // largest allowed write-multiple frame
    task automatic test_longest_frame();
        send_word(make_header(8'($urandom), FUNC_WRITE_MULTIPLE, 16'($urandom),
                              16'(MAX_WORDS), 16'($urandom)));
        for (int i = 0; i < MAX_WORDS; i++) begin
            send_word(make_data(16'($urandom)));
        end
        wait_drained();
    endtask

    // mostly well-formed requests with random content, some noise and broken sequences
    task automatic test_random_traffic(input int count);
        int         pick;
        logic [1:0] func;
        logic [15:0] qty;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (words_left != 0) begin
                if (pick < 5) begin
                    send_word(make_header(8'($urandom), 2'($urandom), 16'($urandom),
                                          16'($urandom), 16'($urandom)));
                end else begin
                    send_word(make_data(16'($urandom)));
                end
            end else if (pick < 8) begin
                send_word(make_data(16'($urandom)));
            end else if (pick < 14) begin
                func = 2'($urandom_range(2, 3));
                qty  = 16'($urandom_range(MAX_WORDS + 1, 65535));
                send_word(make_header(8'($urandom), func, 16'($urandom), qty, 16'($urandom)));
            end else if (pick < 40) begin
                send_word(make_header(8'($urandom), FUNC_READ_HOLDING, 16'($urandom),
                                      16'($urandom), 16'($urandom)));
            end else if (pick < 65) begin
                send_word(make_header(8'($urandom), FUNC_WRITE_SINGLE, 16'($urandom),
                                      16'($urandom), 16'($urandom)));
            end else begin
                // mostly short frames, now and then a longer one
                func = 2'($urandom_range(2, 3));
                qty  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 40))
                                                   : 16'($urandom_range(0, 6));
                send_word(make_header(8'($urandom), func, 16'($urandom), qty, 16'($urandom)));
            end
        end
        // close any frame left open
        while (words_left != 0) begin
            send_word(make_data(16'($urandom)));
        end
        wait_drained();
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_read_holding();
        test_write_single();
        test_write_multiple();
        test_protocol_errors();
        test_back_pressure();
        test_longest_frame();
        test_random_traffic(RANDOM_WORDS);

        // let any stray output show up before the verdict
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
